// ----- rtl/core/bavg_pkg.sv -----
package bavg_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int RING_DEPTH   = 256;
    localparam int MAX_BLOCK    = 64;
    localparam int LEN_BITS     = 7;
    localparam int WIDTH_BITS   = $clog2(RING_DEPTH) + 1;
    localparam int SLOT_BITS    = $clog2(RING_DEPTH);
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_BLOCK);
    localparam int REM_BITS     = $clog2(MAX_BLOCK);
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = WIDTH_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_LEN    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH = 1'd1;

    localparam logic [LEN_BITS-1:0]   LEN_RESET   = LEN_BITS'(40);
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(RING_DEPTH);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
    } alu_op_t;

    typedef struct packed {
        logic                   lt;
        logic [SAMPLE_BITS-1:0] diff;
    } alu_res_t;

    typedef struct packed {
        logic                   en;
        logic [SLOT_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] data;
    } ring_wr_t;

endpackage

// ----- rtl/core/bavg_if.sv -----
interface bavg_in_if;
    logic                             valid;
    logic                             ready;
    logic [bavg_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface bavg_out_if;
    logic                             valid;
    logic                             ready;
    logic [bavg_pkg::SAMPLE_BITS-1:0] average;
    logic [bavg_pkg::SLOT_BITS-1:0]   slot;
    logic [bavg_pkg::SAMPLE_BITS-1:0] peak;

    modport source (output valid, output average, output slot, output peak, input ready);
    modport sink (input valid, input average, input slot, input peak, output ready);
endinterface

// ----- rtl/core/bavg_alu.sv -----
module bavg_alu
(
    input  bavg_pkg::alu_op_t  op,
    output bavg_pkg::alu_res_t res
);

    logic [bavg_pkg::SAMPLE_BITS:0] diff_wide;

    // one subtractor: divider trial subtract and peak compare
    assign diff_wide = {1'b0, op.a} - {1'b0, op.b};
    assign res.lt    = diff_wide[bavg_pkg::SAMPLE_BITS];
    assign res.diff  = diff_wide[bavg_pkg::SAMPLE_BITS-1:0];

endmodule

// ----- rtl/core/bavg_ring.sv -----
module bavg_ring
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  bavg_pkg::ring_wr_t               wr,
    input  logic [bavg_pkg::SLOT_BITS-1:0]   rd_addr,
    output logic [bavg_pkg::SAMPLE_BITS-1:0] rd_data
);

    logic [bavg_pkg::SAMPLE_BITS-1:0] mem [bavg_pkg::RING_DEPTH];
    logic [bavg_pkg::RING_DEPTH-1:0]  valid_reg;
    logic [bavg_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // unwritten slots read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/block_average_ring_with_peak.sv -----
// block average ring with peak tracking
//
// samples (sink): one unsigned sample per word. averages (source): one word per
// completed block carrying the block average, the ring slot it was stored in and
// the maximum over ring slots 0 .. window_width-1 after that store.
// cfg_we/cfg_index/cfg_data write block_len (index 0) and window_width (index 1);
// write only while the block is idle.
//
// a sample that does not complete a block is taken while ready stays high.
// a sample that completes a block starts the sequencer: restoring division
// through the shared subtractor, the ring store, then a ring rescan through
// the same subtractor and one registered memory read port, then the load of
// the output register.
// ready returns only once the output register has been loaded.
// the output register holds a result until taken; the next samples are accepted
// meanwhile, and only the next block completion waits for it to drain.
// reset clears the sum, count, pointer, peak, output valid and all ring slots
// (per-slot valid flags), so no clearing pass is needed.
module block_average_ring_with_peak
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bavg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bavg_pkg::CFG_BITS-1:0]       cfg_data,
    bavg_in_if.sink                             samples,
    bavg_out_if.source                          averages
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int SB = bavg_pkg::SAMPLE_BITS;
    localparam int QB = bavg_pkg::SUM_BITS;
    localparam int RB = bavg_pkg::REM_BITS;
    localparam int LB = bavg_pkg::LEN_BITS;
    localparam int WB = bavg_pkg::WIDTH_BITS;
    localparam int PB = bavg_pkg::SLOT_BITS;

    logic [2:0]                       state_reg, state_next;
    logic [LB-1:0]                    len_reg;
    logic [WB-1:0]                    width_reg;
    logic [QB-1:0]                    sum_reg, sum_next;
    logic [LB-1:0]                    count_reg, count_next;
    logic [PB-1:0]                    slot_reg, slot_next;
    logic [QB-1:0]                    quo_reg, quo_next;
    logic [RB-1:0]                    rem_reg, rem_next;
    logic [bavg_pkg::STEP_BITS-1:0]   step_reg, step_next;
    logic [WB-1:0]                    idx_reg, idx_next;
    logic                             pend_reg, pend_next;
    logic [SB-1:0]                    peak_reg, peak_next;
    logic [SB-1:0]                    avg_reg, avg_next;
    logic                             ov_reg, ov_next;
    logic [SB-1:0]                    oavg_reg, oavg_next;
    logic [PB-1:0]                    oslot_reg, oslot_next;
    logic [SB-1:0]                    opeak_reg, opeak_next;

    logic [LB-1:0]                    len_eff;
    logic [WB-1:0]                    width_eff;
    logic [QB-1:0]                    sum_add;
    logic [LB-1:0]                    cnt_add;
    logic [WB-1:0]                    slot_inc;
    logic [RB:0]                      shifted;
    logic [SB-1:0]                    avg_sat;
    logic [SB-1:0]                    rd_data;
    bavg_pkg::alu_op_t                alu_op;
    bavg_pkg::alu_res_t               alu_res;
    bavg_pkg::ring_wr_t               ring_wr;

    bavg_alu u_alu
    (
        .op  (alu_op),
        .res (alu_res)
    );

    bavg_ring u_ring
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ring_wr),
        .rd_addr (idx_reg[PB-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (len_reg == '0)
            len_eff = LB'(1);
        else if (len_reg > LB'(bavg_pkg::MAX_BLOCK))
            len_eff = LB'(bavg_pkg::MAX_BLOCK);
        else
            len_eff = len_reg;

        if (width_reg == '0)
            width_eff = WB'(1);
        else if (width_reg > WB'(bavg_pkg::RING_DEPTH))
            width_eff = WB'(bavg_pkg::RING_DEPTH);
        else
            width_eff = width_reg;
    end

    assign sum_add  = sum_reg + QB'(samples.sample);
    assign cnt_add  = count_reg + LB'(1);
    assign slot_inc = {1'b0, slot_reg} + WB'(1);
    assign shifted  = {rem_reg, quo_reg[QB-1]};
    assign avg_sat  = (|quo_reg[QB-1:SB]) ? {SB{1'b1}} : quo_reg[SB-1:0];

    assign samples.ready    = (state_reg == ST_IDLE);
    assign averages.valid   = ov_reg;
    assign averages.average = oavg_reg;
    assign averages.slot    = oslot_reg;
    assign averages.peak    = opeak_reg;

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        peak_next  = peak_reg;
        avg_next   = avg_reg;
        oavg_next  = oavg_reg;
        oslot_next = oslot_reg;
        opeak_next = opeak_reg;
        ov_next    = ov_reg && !averages.ready;
        ring_wr    = '{en: 1'b0, addr: slot_reg, data: avg_sat};
        alu_op     = '{a: peak_reg, b: rd_data};

        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    if (cnt_add >= len_eff)
                    begin
                        // pointer advances before the store
                        slot_next  = (slot_inc >= width_eff) ? '0 : slot_inc[PB-1:0];
                        quo_next   = sum_add;
                        rem_next   = '0;
                        step_next  = '0;
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = cnt_add;
                    end
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                alu_op    = '{a: SB'(shifted), b: SB'(len_eff)};
                quo_next  = {quo_reg[QB-2:0], !alu_res.lt};
                rem_next  = alu_res.lt ? shifted[RB-1:0] : alu_res.diff[RB-1:0];
                step_next = step_reg + bavg_pkg::STEP_BITS'(1);
                if (step_reg == bavg_pkg::STEP_BITS'(bavg_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ring_wr.en = 1'b1;
                avg_next   = avg_sat;
                peak_next  = '0;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // read issued at idx, data compared in the next cycle
                if (idx_reg != width_eff)
                begin
                    idx_next  = idx_reg + WB'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && alu_res.lt)
                begin
                    peak_next = rd_data;
                end
                if (idx_reg == width_eff && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || averages.ready)
                begin
                    ov_next    = 1'b1;
                    oavg_next  = avg_reg;
                    oslot_next = slot_reg;
                    opeak_next = peak_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= bavg_pkg::LEN_RESET;
            width_reg <= bavg_pkg::WIDTH_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
            slot_reg  <= '0;
            peak_reg  <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            peak_reg  <= peak_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bavg_pkg::CFG_BLOCK_LEN:    len_reg   <= cfg_data[LB-1:0];
                    bavg_pkg::CFG_WINDOW_WIDTH: width_reg <= cfg_data[WB-1:0];
                    default:                    len_reg   <= len_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        idx_reg   <= idx_next;
        avg_reg   <= avg_next;
        oavg_reg  <= oavg_next;
        oslot_reg <= oslot_next;
        opeak_reg <= opeak_next;
    end

endmodule

// ----- rtl/core/bavg_chk.sv -----
module bavg_chk
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [bavg_pkg::SAMPLE_BITS-1:0] out_average,
    input logic [bavg_pkg::SLOT_BITS-1:0]   out_slot,
    input logic [bavg_pkg::SAMPLE_BITS-1:0] out_peak
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_average)
            && $stable(out_slot) && $stable(out_peak))
        else $error("result word changed while stalled");

    // the peak covers the slot just written
    a_peak_ge_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_peak >= out_average)
        else $error("peak below the stored average");

    // a new result is only loaded while the sequencer is busy
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

    // no result during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind block_average_ring_with_peak bavg_chk u_bavg_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (samples.ready),
    .out_valid   (averages.valid),
    .out_ready   (averages.ready),
    .out_average (averages.average),
    .out_slot    (averages.slot),
    .out_peak    (averages.peak)
);
